// ===== rtl/core/slu_pkg.sv =====
// ----------------------------------------------------------------------------
// slu_pkg
// Shared types and constants for the sequential list set-union unit.
// ----------------------------------------------------------------------------
package slu_pkg;

  // List storage geometry
  localparam int CAPACITY = 256;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = ADDR_W + 1;

  // Item field widths
  localparam int ACT_W = 3;
  localparam int VAL_W = 32;
  localparam int POS_W = 9;
  localparam int ST_W  = 2;
  localparam int IDX_W = 8;

  // Operation codes
  typedef enum logic [ACT_W-1:0] {
    ACT_CLEAR  = 3'd0,
    ACT_APPEND = 3'd1,
    ACT_UNION  = 3'd2,
    ACT_INSERT = 3'd3,
    ACT_SEARCH = 3'd4
  } action_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK      = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISS    = 2'd3
  } status_t;

  // Source of the result index
  typedef enum logic [1:0] {
    IDX_ZERO = 2'd0,
    IDX_CNT  = 2'd1,
    IDX_HIT  = 2'd2,
    IDX_POS  = 2'd3
  } idx_sel_t;

  // Controller to datapath commands
  typedef struct packed {
    logic     capture;       // latch the input item
    logic     clear_cnt;     // empty the list
    logic     search_start;  // rewind read pointer to entry 0
    logic     search_step;   // read next entry for compare
    logic     shift_start;   // set read pointer to the count
    logic     shift_step;    // move one entry up
    logic     write_append;  // store key at the end
    logic     write_insert;  // store key at the insert slot
    logic     res_we;        // load result status and index
    status_t  res_status;
    idx_sel_t res_idx_sel;
    logic     load_out;      // move result into the output register
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             pos_bad;
    logic             hit;
    logic             search_end;
    logic             shift_end;
    logic             out_free;
  } stat_t;

endpackage

// ===== rtl/core/sequential_list_set_union_unit.sv =====
// ----------------------------------------------------------------------------
// sequential_list_set_union_unit
// Ordered list of signed 32-bit values with append, union insert,
// positional insert, search and clear.
//
//   channel | handshake            | payload
//   --------+----------------------+-------------------------
//   in      | in_valid / in_stall  | action, value, position
//   out     | out_valid / out_stall| status, index, count
//
// One item at a time. Clear, append, unused codes and rejected inserts go
// from decode straight to the result. Search and union insert walk the list
// through the single memory read port. Positional insert moves one entry per
// cycle from the end down to the slot, then stores the key in the slot.
// Reset empties the list at once; entries are only read below the count.
// A result waits in the output register while out_stall is high; the next
// item is already accepted and held back only at its own result.
// ----------------------------------------------------------------------------
module sequential_list_set_union_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [slu_pkg::ACT_W-1:0]         action,
  input  logic signed [slu_pkg::VAL_W-1:0]  value,
  input  logic [slu_pkg::POS_W-1:0]         position,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [slu_pkg::ST_W-1:0]          status,
  output logic [slu_pkg::IDX_W-1:0]         index,
  output logic [slu_pkg::CNT_W-1:0]         count
);
  import slu_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  slu_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  slu_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .action    (action),
    .value     (value),
    .position  (position),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .status    (status),
    .index     (index),
    .count     (count)
  );

endmodule

// ===== rtl/core/slu_dpath.sv =====
// ----------------------------------------------------------------------------
// slu_dpath
// List memory, element count, scan pointer, key compare and result registers.
// ----------------------------------------------------------------------------
module slu_dpath (
  input  logic                              clk,
  input  logic                              rst,
  input  slu_pkg::cmd_t                     cmd,
  output slu_pkg::stat_t                    stat,
  input  logic [slu_pkg::ACT_W-1:0]         action,
  input  logic signed [slu_pkg::VAL_W-1:0]  value,
  input  logic [slu_pkg::POS_W-1:0]         position,
  input  logic                              out_stall,
  output logic                              out_valid,
  output logic [slu_pkg::ST_W-1:0]          status,
  output logic [slu_pkg::IDX_W-1:0]         index,
  output logic [slu_pkg::CNT_W-1:0]         count
);
  import slu_pkg::*;

  // List storage, one write and one registered read per cycle
  logic [VAL_W-1:0] mem [CAPACITY];

  // Captured item
  logic [ACT_W-1:0] act;
  logic [VAL_W-1:0] key;
  logic [POS_W-1:0] pos;

  // Control registers
  logic [CNT_W-1:0]  elem_cnt;
  logic [CNT_W-1:0]  ptr;
  logic              rd_valid;
  logic [ADDR_W-1:0] rd_addr;
  logic [VAL_W-1:0]  rdata;

  // Result registers
  status_t           res_status;
  logic [IDX_W-1:0]  res_index;

  logic [CNT_W-1:0]  ptr_dec;
  logic [CNT_W-1:0]  pos_m1;
  logic              rd_issue;
  logic [ADDR_W-1:0] rd_addr_next;
  logic              wr_en;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;
  logic [IDX_W-1:0]  idx_mux;

  assign ptr_dec = ptr - CNT_W'(1);
  assign pos_m1  = pos - POS_W'(1);

  // Read issue: search walks up, shift walks down
  always_comb begin
    rd_issue     = 1'b0;
    rd_addr_next = ptr[ADDR_W-1:0];
    if (cmd.search_step && (ptr < elem_cnt)) begin
      rd_issue     = 1'b1;
      rd_addr_next = ptr[ADDR_W-1:0];
    end else if (cmd.shift_step && (ptr > pos_m1)) begin
      rd_issue     = 1'b1;
      rd_addr_next = ptr_dec[ADDR_W-1:0];
    end
  end

  // Write port select
  always_comb begin
    wr_en   = 1'b0;
    wr_addr = elem_cnt[ADDR_W-1:0];
    wr_data = key;
    if (cmd.write_append) begin
      wr_en   = 1'b1;
      wr_addr = elem_cnt[ADDR_W-1:0];
    end else if (cmd.write_insert) begin
      wr_en   = 1'b1;
      wr_addr = pos_m1[ADDR_W-1:0];
    end else if (cmd.shift_step && rd_valid) begin
      wr_en   = 1'b1;
      wr_addr = rd_addr + ADDR_W'(1);
      wr_data = rdata;
    end
  end

  // Memory array
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_issue) begin
      rdata   <= mem[rd_addr_next];
      rd_addr <= rd_addr_next;
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act <= action;
      key <= value;
      pos <= position;
    end
  end

  // Count, pointer and read-valid
  always_ff @(posedge clk) begin
    if (rst) begin
      elem_cnt <= '0;
      ptr      <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (cmd.clear_cnt) begin
        elem_cnt <= '0;
      end else if (cmd.write_append || cmd.write_insert) begin
        elem_cnt <= elem_cnt + CNT_W'(1);
      end
      if (cmd.search_start) begin
        ptr      <= '0;
        rd_valid <= 1'b0;
      end else if (cmd.shift_start) begin
        ptr      <= elem_cnt;
        rd_valid <= 1'b0;
      end else if (cmd.search_step || cmd.shift_step) begin
        rd_valid <= rd_issue;
        if (rd_issue) begin
          ptr <= cmd.search_step ? ptr + CNT_W'(1) : ptr_dec;
        end
      end
    end
  end

  // Result index select
  always_comb begin
    case (cmd.res_idx_sel)
      IDX_ZERO: idx_mux = '0;
      IDX_CNT:  idx_mux = elem_cnt[IDX_W-1:0];
      IDX_HIT:  idx_mux = rd_addr;
      IDX_POS:  idx_mux = pos_m1[IDX_W-1:0];
      default:  idx_mux = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.res_we) begin
      res_status <= cmd.res_status;
      res_index  <= idx_mux;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status <= res_status;
      index  <= res_index;
      count  <= elem_cnt;
    end
  end

  // Status toward the controller
  always_comb begin
    stat.act        = act;
    stat.full       = (elem_cnt == CNT_W'(CAPACITY));
    stat.pos_bad    = (pos == '0) || ({1'b0, pos} > ({1'b0, elem_cnt} + (CNT_W + 1)'(1)));
    stat.hit        = rd_valid && (rdata == key);
    stat.search_end = !rd_valid && (ptr >= elem_cnt);
    stat.shift_end  = !rd_valid && (ptr <= pos_m1);
    stat.out_free   = !out_valid || !out_stall;
  end

endmodule

// ===== rtl/core/slu_ctrl.sv =====
// ----------------------------------------------------------------------------
// slu_ctrl
// Sequencer for the list operations: decode, scan, shift, write, deliver.
// ----------------------------------------------------------------------------
module slu_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_stall,
  input  slu_pkg::stat_t stat,
  output slu_pkg::cmd_t  cmd
);
  import slu_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DECODE = 6'b000010,
    S_SEARCH = 6'b000100,
    S_SHIFT  = 6'b001000,
    S_WRITE  = 6'b010000,
    S_DONE   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    cmd.res_status  = ST_OK;
    cmd.res_idx_sel = IDX_ZERO;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        case (stat.act)
          ACT_CLEAR: begin
            cmd.clear_cnt = 1'b1;
            cmd.res_we    = 1'b1;
            state_next    = S_DONE;
          end
          ACT_APPEND: begin
            cmd.res_we = 1'b1;
            if (stat.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.write_append = 1'b1;
              cmd.res_idx_sel  = IDX_CNT;
            end
            state_next = S_DONE;
          end
          ACT_UNION, ACT_SEARCH: begin
            cmd.search_start = 1'b1;
            state_next       = S_SEARCH;
          end
          ACT_INSERT: begin
            if (stat.pos_bad) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_BAD_POS;
              state_next     = S_DONE;
            end else if (stat.full) begin
              cmd.res_we     = 1'b1;
              cmd.res_status = ST_FULL;
              state_next     = S_DONE;
            end else begin
              cmd.shift_start = 1'b1;
              state_next      = S_SHIFT;
            end
          end
          default: begin
            // unused codes: no change, ok
            cmd.res_we = 1'b1;
            state_next = S_DONE;
          end
        endcase
      end
      S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (stat.hit) begin
          cmd.res_we = 1'b1;
          if (stat.act == ACT_SEARCH) begin
            cmd.res_idx_sel = IDX_HIT;
          end else begin
            cmd.res_status = ST_MISS;
          end
          state_next = S_DONE;
        end else if (stat.search_end) begin
          cmd.res_we = 1'b1;
          if (stat.act == ACT_SEARCH) begin
            cmd.res_status = ST_MISS;
          end else if (stat.full) begin
            cmd.res_status = ST_FULL;
          end else begin
            cmd.write_append = 1'b1;
            cmd.res_idx_sel  = IDX_CNT;
          end
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        cmd.shift_step = 1'b1;
        if (stat.shift_end) begin
          state_next = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd.write_insert = 1'b1;
        cmd.res_we       = 1'b1;
        cmd.res_idx_sel  = IDX_POS;
        state_next       = S_DONE;
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
